>>> rtl/core/length_prefixed_name_deframer_defines.svh
// Assertion macros for the length-prefixed name deframer checker.
// No dependencies; the including scope must provide clk and rst_n.
`ifndef LENGTH_PREFIXED_NAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_NAME_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define LPND_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPND_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lpnd_pkg.sv
// Shared types and constants for the length-prefixed name deframer.
// No dependencies.
package lpnd_pkg;

  localparam int unsigned MAX_NAMES      = 255;
  localparam int unsigned BYTE_LIMIT_MAX = 65535;
  localparam int unsigned BYTE_MAX       = 255;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  typedef enum logic [1:0] {
    PH_COUNT  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BYTES  = 2'd2,
    PH_FULL   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_COUNT   = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_LONG    = 3'd4,
    ST_NOTBYTE = 3'd5,
    ST_TRAIL   = 3'd6
  } status_t;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_EXPECTED_COUNT = 1'b0,
    REG_MAX_TOTAL      = 1'b1
  } reg_idx_t;

endpackage

>>> rtl/core/lpnd_in_if.sv
// Input word channel of the deframer: valid/ready plus the input word fields.
// No dependencies.
interface lpnd_in_if;
  logic        valid;
  logic        ready;
  logic        carries_word;
  logic [31:0] word;
  logic        last;

  modport source (output valid, carries_word, word, last, input ready);
  modport sink   (input valid, carries_word, word, last, output ready);
endinterface

>>> rtl/core/lpnd_out_if.sv
// Result channel of the deframer: valid/ready plus the result fields.
// No dependencies.
interface lpnd_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic [7:0] name_index;
  logic       name_done;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, has_byte, data_byte, name_index, name_done, done_res,
                  status, input ready);
  modport sink   (input valid, has_byte, data_byte, name_index, name_done, done_res,
                  status, output ready);
endinterface

>>> rtl/core/length_prefixed_name_deframer.sv
// Length-prefixed name deframer: takes one word per cycle while out_ch is not stalled, gives one result per word.
// Depends on lpnd_pkg, lpnd_in_if and lpnd_out_if.
//
// Throughput is one word per clock while out_ch is not stalled: a word is captured
// in the input register, parsed against the counters in a single combinational pass
// and written to the result register, which also holds a result while out_ch is
// stalled. Each word gives exactly one result; the word marked last carries the
// final status and returns the parser to the count word. Registers should be
// written only while no word is in flight. There is no clearing pass after reset.
module length_prefixed_name_deframer
  import lpnd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lpnd_in_if.sink           in_ch,
  lpnd_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // configuration
  logic [7:0]  expected_count_r;
  logic [15:0] max_total_r;
  reg_idx_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_count_r <= 8'd0;
      max_total_r      <= 16'd1024;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_EXPECTED_COUNT: expected_count_r <= pwdata[7:0];
        REG_MAX_TOTAL:      max_total_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EXPECTED_COUNT: prdata = {24'd0, expected_count_r};
      REG_MAX_TOTAL:      prdata = {16'd0, max_total_r};
      default:            prdata = '0;
    endcase
  end

  // input register
  logic        s1_valid_r;
  logic        s1_carries_r;
  logic [31:0] s1_word_r;
  logic        s1_last_r;
  logic        advance;
  logic        fire;

  assign advance     = !out_ch.valid || out_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_carries_r <= in_ch.carries_word;
      s1_word_r    <= in_ch.word;
      s1_last_r    <= in_ch.last;
    end
  end

  // parser state
  phase_t      phase_r, phase_nxt, phase_tk;
  logic [7:0]  names_left_r, names_left_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [16:0] byte_total_r, byte_total_nxt;
  logic [7:0]  cur_name_r, cur_name_nxt;
  status_t     err_r, err_nxt, err_tk;

  logic        take;
  logic [32:0] total_sum;
  logic [16:0] limit;
  logic        too_long;
  logic        not_byte;
  logic        count_bad;

  assign take      = s1_carries_r && (err_r == ST_OK);
  assign total_sum = {16'd0, byte_total_r} + {1'b0, s1_word_r};
  assign limit     = (max_total_r > 16'(BYTE_LIMIT_MAX)) ? 17'(BYTE_LIMIT_MAX)
                                                         : {1'b0, max_total_r};
  assign too_long  = total_sum > {16'd0, limit};
  assign not_byte  = s1_word_r > 32'(BYTE_MAX);
  assign count_bad = (s1_word_r != {24'd0, expected_count_r})
                  || (s1_word_r > 32'(MAX_NAMES));

  // next state
  always_comb begin
    phase_tk       = phase_r;
    err_tk         = err_r;
    names_left_nxt = names_left_r;
    bytes_left_nxt = bytes_left_r;
    byte_total_nxt = byte_total_r;
    cur_name_nxt   = cur_name_r;
    if (take) begin
      case (phase_r)
        PH_COUNT: begin
          if (count_bad) begin
            err_tk = ST_COUNT;
          end else begin
            names_left_nxt = s1_word_r[7:0];
            phase_tk       = (s1_word_r[7:0] == 8'd0) ? PH_FULL : PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (too_long) begin
            err_tk = ST_LONG;
          end else begin
            byte_total_nxt = total_sum[16:0];
            bytes_left_nxt = s1_word_r[15:0];
            if (s1_word_r[15:0] == 16'd0) begin
              cur_name_nxt   = cur_name_r + 8'd1;
              names_left_nxt = names_left_r - 8'd1;
              phase_tk       = (names_left_r == 8'd1) ? PH_FULL : PH_LENGTH;
            end else begin
              phase_tk = PH_BYTES;
            end
          end
        end
        PH_BYTES: begin
          if (not_byte) begin
            err_tk = ST_NOTBYTE;
          end else begin
            bytes_left_nxt = bytes_left_r - 16'd1;
            if (bytes_left_r == 16'd1) begin
              cur_name_nxt   = cur_name_r + 8'd1;
              names_left_nxt = names_left_r - 8'd1;
              phase_tk       = (names_left_r == 8'd1) ? PH_FULL : PH_LENGTH;
            end
          end
        end
        default: err_tk = ST_TRAIL;
      endcase
    end
    phase_nxt = phase_tk;
    err_nxt   = err_tk;
    if (s1_last_r) begin
      phase_nxt      = PH_COUNT;
      err_nxt        = ST_OK;
      names_left_nxt = 8'd0;
      bytes_left_nxt = 16'd0;
      byte_total_nxt = 17'd0;
      cur_name_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      err_r        <= ST_OK;
      names_left_r <= 8'd0;
      bytes_left_r <= 16'd0;
      byte_total_r <= 17'd0;
      cur_name_r   <= 8'd0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      err_r        <= err_nxt;
      names_left_r <= names_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_total_r <= byte_total_nxt;
      cur_name_r   <= cur_name_nxt;
    end
  end

  // result fields
  logic       res_has_byte;
  logic [7:0] res_data_byte;
  logic [7:0] res_name_index;
  logic       res_name_done;
  status_t    res_status;

  always_comb begin
    res_has_byte  = take && (phase_r == PH_BYTES) && !not_byte;
    res_name_done = take && (((phase_r == PH_LENGTH) && !too_long
                              && (s1_word_r[15:0] == 16'd0))
                          || (res_has_byte && (bytes_left_r == 16'd1)));
    res_data_byte  = res_has_byte ? s1_word_r[7:0] : 8'd0;
    res_name_index = (res_has_byte || res_name_done) ? cur_name_r : 8'd0;
    res_status     = ST_OK;
    if (s1_last_r) begin
      if (err_tk != ST_OK) begin
        res_status = err_tk;
      end else if (phase_tk == PH_COUNT) begin
        res_status = ST_EMPTY;
      end else if (phase_tk != PH_FULL) begin
        res_status = ST_TRUNC;
      end
    end
  end

  // result register
  logic       out_valid_r;
  logic       out_has_byte_r;
  logic [7:0] out_data_byte_r;
  logic [7:0] out_name_index_r;
  logic       out_name_done_r;
  logic       out_done_r;
  status_t    out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_has_byte_r   <= res_has_byte;
      out_data_byte_r  <= res_data_byte;
      out_name_index_r <= res_name_index;
      out_name_done_r  <= res_name_done;
      out_done_r       <= s1_last_r;
      out_status_r     <= res_status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.has_byte   = out_has_byte_r;
  assign out_ch.data_byte  = out_data_byte_r;
  assign out_ch.name_index = out_name_index_r;
  assign out_ch.name_done  = out_name_done_r;
  assign out_ch.done_res   = out_done_r;
  assign out_ch.status     = out_status_r;

endmodule

>>> rtl/core/lpnd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
// Depends on lpnd_pkg and length_prefixed_name_deframer_defines.svh.
`include "length_prefixed_name_deframer_defines.svh"

module lpnd_checker
  import lpnd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_has_byte,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_name_index,
  input logic       out_name_done,
  input logic       out_done_res,
  input logic [2:0] out_status
);

  `LPND_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status), "result dropped while stalled")
  `LPND_ASSERT_IMP(a_byte_zero, out_valid && !out_has_byte, out_data_byte == 8'd0, "data_byte set without a byte")
  `LPND_ASSERT_IMP(a_status_zero, out_valid && !out_done_res, out_status == ST_OK, "status set before payload end")
  `LPND_ASSERT_IMP(a_index_zero, out_valid && !out_has_byte && !out_name_done, out_name_index == 8'd0, "name_index set with no byte or name end")

endmodule

bind length_prefixed_name_deframer lpnd_checker u_lpnd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_has_byte   (out_ch.has_byte),
  .out_data_byte  (out_ch.data_byte),
  .out_name_index (out_ch.name_index),
  .out_name_done  (out_ch.name_done),
  .out_done_res   (out_ch.done_res),
  .out_status     (out_ch.status)
);
